// File: rtl/asa_pkg.sv
// Shared types and constants for the aligned stack allocator.
// No dependencies; imported by aligned_stack_allocator and by the testbench.
`timescale 1ns / 1ps

package asa_pkg;

    localparam int unsigned MAX_CHUNKS_DEF = 64;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned BYTES_W = 21;
    localparam int unsigned ALIGN_W = 13;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned COUNT_W = 7;

    localparam logic [BYTES_W-1:0] POOL_BYTES_RST = 21'd1048576;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_ADDR  = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_POOL_BASE  = 1'b0;
    localparam logic CFG_POOL_BYTES = 1'b1;

    typedef logic [BYTES_W-1:0] bytes_t;
    typedef logic [ADDR_W-1:0]  addr_t;

endpackage

// File: rtl/asa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the padded-size stack of the allocator.
`timescale 1ns / 1ps

module asa_ram #(
    parameter int unsigned WIDTH = 21,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/aligned_stack_allocator.sv
// Top level of the aligned stack allocator: request decode, stack control, result register.
// Depends on asa_pkg and asa_ram.
`timescale 1ns / 1ps

// Usage
//   Requests arrive as beats on the s_ channel: s_tuser carries the kind (allocate, free top
//   block, reset stack) and s_tdata the request size, alignment and address to free.
//   Each request yields exactly one result beat on the m_ channel with status, block address,
//   bytes in use and live block count.
//   The result is written to the output register at the edge that accepts the request.
//   Throughput is one request per cycle while results are taken. The top two padded sizes
//   sit in registers and the rest of the stack lives in a RAM whose next entry is read ahead,
//   so pushes and pops can follow each other on every cycle.
//   When the receiver stalls, the output register holds its beat and s_tready drops until that
//   beat is taken; a new request is accepted in the same cycle the old result leaves.
//   After reset the stack is empty, pool_base is 0 and pool_bytes is 1048576.
//   Configuration is written through cfg_we, cfg_addr and cfg_wdata while no request is in
//   flight; a write takes effect at the next edge.

module aligned_stack_allocator
    import asa_pkg::*;
#(
    parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // request_bytes[20:0], align_bytes[33:21],
                                   // free_address[65:34], zero fill
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // status[2:0], block_address[34:3], used_bytes[55:35],
                                   // block_count[62:56], zero fill
);

    localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
    localparam int unsigned AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

    // Configuration registers
    addr_t  pool_base_reg;
    bytes_t pool_bytes_reg;

    // Allocator state; top_size_reg and next_size_reg hold the two uppermost stack entries.
    bytes_t        top_reg,  top_next;
    logic [CW-1:0] live_reg, live_next;
    bytes_t        top_size_reg,  top_size_next;
    bytes_t        next_size_reg, next_size_next;
    logic          byp_valid_reg;
    bytes_t        byp_data_reg;

    // Result register
    logic                m_valid_reg;
    logic [STAT_W-1:0]   status_reg,  status_next;
    addr_t               baddr_reg,   baddr_next;

    logic accept;

    logic [KIND_W-1:0]  kind;
    bytes_t             req;
    logic [ALIGN_W-1:0] align;
    addr_t              faddr;

    addr_t              top_abs;
    logic [ALIGN_W-1:0] pad_mask;
    logic [ALIGN_W-1:0] pad;
    logic [BYTES_W+1:0] need;
    logic [BYTES_W:0]   total;
    addr_t              blk_start;
    addr_t              rel;
    logic               full;
    logic               push;

    bytes_t        third_size;
    bytes_t        ram_rdata;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;

    assign kind  = s_tuser;
    assign req   = s_tdata[20:0];
    assign align = s_tdata[33:21];
    assign faddr = s_tdata[65:34];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign top_abs   = pool_base_reg + {{(ADDR_W-BYTES_W){1'b0}}, top_reg};
    assign pad_mask  = (align == '0) ? '0 : (align - ALIGN_W'(1));
    assign pad       = (~top_abs[ALIGN_W-1:0] + ALIGN_W'(1)) & pad_mask;
    assign need      = {2'b00, top_reg} + {{(BYTES_W+2-ALIGN_W){1'b0}}, pad}
                       + {2'b00, req};
    assign total     = {{(BYTES_W+1-ALIGN_W){1'b0}}, pad} + {1'b0, req};
    assign blk_start = top_abs - {{(ADDR_W-BYTES_W){1'b0}}, top_size_reg};
    assign rel       = faddr - blk_start;
    assign full      = (live_reg >= CW'(MAX_CHUNKS));

    // The entry just below the two cached ones, with the write of the previous cycle forwarded.
    assign third_size = byp_valid_reg ? byp_data_reg : ram_rdata;

    always_comb begin
        top_next       = top_reg;
        live_next      = live_reg;
        top_size_next  = top_size_reg;
        next_size_next = next_size_reg;
        status_next    = ST_OK;
        baddr_next     = '0;
        push           = 1'b0;
        if (accept) begin
            case (kind)
                KIND_ALLOC: begin
                    if (full) begin
                        status_next = ST_TABLE_FULL;
                    end else if (need > {2'b00, pool_bytes_reg}) begin
                        status_next = ST_NO_SPACE;
                    end else begin
                        push           = 1'b1;
                        baddr_next     = top_abs + {{(ADDR_W-ALIGN_W){1'b0}}, pad};
                        top_next       = top_reg + total[BYTES_W-1:0];
                        live_next      = live_reg + CW'(1);
                        top_size_next  = total[BYTES_W-1:0];
                        next_size_next = top_size_reg;
                    end
                end
                KIND_FREE: begin
                    if (live_reg == '0) begin
                        status_next = ST_EMPTY;
                    end else if (rel > {{(ADDR_W-BYTES_W){1'b0}}, top_size_reg}) begin
                        status_next = ST_BAD_ADDR;
                    end else begin
                        top_next       = top_reg - top_size_reg;
                        live_next      = live_reg - CW'(1);
                        top_size_next  = next_size_reg;
                        next_size_next = third_size;
                    end
                end
                KIND_RESET: begin
                    top_next  = '0;
                    live_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // The RAM holds every entry below the two cached ones; a push spills the second one.
    assign ram_waddr = AW'(live_reg - CW'(2));
    assign ram_raddr = AW'(live_next - CW'(3));

    asa_ram #(
        .WIDTH (BYTES_W),
        .DEPTH (MAX_CHUNKS)
    ) u_size_ram (
        .aclk  (aclk),
        .we    (push && (live_reg >= CW'(2))),
        .waddr (ram_waddr),
        .wdata (next_size_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg  <= '0;
            pool_bytes_reg <= POOL_BYTES_RST;
            top_reg        <= '0;
            live_reg       <= '0;
            byp_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_POOL_BASE:  pool_base_reg  <= cfg_wdata;
                    CFG_POOL_BYTES: pool_bytes_reg <= cfg_wdata[BYTES_W-1:0];
                    default: begin
                    end
                endcase
            end
            top_reg       <= top_next;
            live_reg      <= live_next;
            byp_valid_reg <= push && (live_reg >= CW'(2));
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        top_size_reg  <= top_size_next;
        next_size_reg <= next_size_next;
        byp_data_reg  <= next_size_reg;
        if (accept) begin
            status_reg <= status_next;
            baddr_reg  <= baddr_next;
        end
    end

    // used_bytes and block_count mirror the state, which only moves when a beat is accepted.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, COUNT_W'(live_reg), top_reg, baddr_reg, status_reg};

endmodule

// File: test/aligned_stack_allocator_chk.sv
// Result checker for the aligned stack allocator: watches the configuration port and both
// stream channels, predicts every result beat and compares it field by field.
// Depends on asa_pkg only.
`timescale 1ns / 1ps

module aligned_stack_allocator_chk
    import asa_pkg::*;
#(
    parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [71:0]  s_tdata,   // request_bytes[20:0], align_bytes[33:21],
                                    // free_address[65:34], zero fill
    input  logic [1:0]   s_tuser,   // kind[1:0]
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,   // status[2:0], block_address[34:3], used_bytes[55:35],
                                    // block_count[62:56], zero fill
    output int           fail_count,
    output int           pending,
    // Stack state as predicted after the last accepted beat, used to aim the frees.
    output int unsigned  live_count,
    output addr_t        top_start,
    output bytes_t       top_size,
    output bytes_t       used
);

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        addr_t              addr;
        bytes_t             used;
        logic [COUNT_W-1:0] count;
    } alloc_result_t;

    addr_t         base_r;
    bytes_t        pool_r;
    bytes_t        top_off;
    int unsigned   depth;
    bytes_t        sizes [MAX_CHUNKS];
    alloc_result_t results_q [$];

    function automatic alloc_result_t apply_request(input logic [KIND_W-1:0] kind,
                                                    input bytes_t req,
                                                    input logic [ALIGN_W-1:0] align,
                                                    input addr_t faddr);
        alloc_result_t r;
        addr_t         top_abs;
        addr_t         pad;
        addr_t         start;
        addr_t         rel;
        bytes_t        sz;
        int unsigned   need;
        r = '0;
        r.status = ST_OK;
        top_abs = base_r + addr_t'(top_off);
        case (kind)
            KIND_ALLOC: begin
                pad = (align == '0) ? '0 : ((-top_abs) & (addr_t'(align) - 32'd1));
                need = int'(top_off) + pad + int'(req);
                if (depth >= MAX_CHUNKS) begin
                    r.status = ST_TABLE_FULL;
                end else if (need > int'(pool_r)) begin
                    r.status = ST_NO_SPACE;
                end else begin
                    r.addr = top_abs + pad;
                    sizes[depth] = bytes_t'(pad + req);
                    top_off = top_off + bytes_t'(pad + req);
                    depth++;
                end
            end
            KIND_FREE: begin
                if (depth == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    sz = sizes[depth - 1];
                    start = top_abs - addr_t'(sz);
                    rel = faddr - start;
                    // Both ends of the top block are accepted, so a zero-size block can go.
                    if (rel > addr_t'(sz)) begin
                        r.status = ST_BAD_ADDR;
                    end else begin
                        depth--;
                        top_off = top_off - sz;
                    end
                end
            end
            KIND_RESET: begin
                top_off = '0;
                depth = 0;
            end
            default: ;
        endcase
        r.used = top_off;
        r.count = COUNT_W'(depth);
        return r;
    endfunction

    always @(posedge aclk) begin
        alloc_result_t got;
        alloc_result_t want;
        if (!aresetn) begin
            base_r = '0;
            pool_r = POOL_BYTES_RST;
            top_off = '0;
            depth = 0;
            results_q.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[2:0];
                got.addr = m_tdata[34:3];
                got.used = m_tdata[55:35];
                got.count = m_tdata[62:56];
                if (results_q.size() == 0) begin
                    $error("result beat with nothing outstanding: status %0d address %h",
                           got.status, got.addr);
                    fail_count++;
                end else begin
                    want = results_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.addr !== want.addr) begin
                        $error("block_address: expected %h, got %h", want.addr, got.addr);
                        fail_count++;
                    end
                    if (got.used !== want.used) begin
                        $error("used_bytes: expected %0d, got %0d", want.used, got.used);
                        fail_count++;
                    end
                    if (got.count !== want.count) begin
                        $error("block_count: expected %0d, got %0d", want.count, got.count);
                        fail_count++;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_addr == CFG_POOL_BASE) begin
                    base_r = cfg_wdata;
                end else begin
                    pool_r = cfg_wdata[BYTES_W-1:0];
                end
            end
            if (s_tvalid && s_tready) begin
                results_q.push_back(apply_request(s_tuser, s_tdata[20:0], s_tdata[33:21],
                                                  s_tdata[65:34]));
            end
        end
        pending = results_q.size();
        live_count = depth;
        used = top_off;
        top_size = (depth == 0) ? '0 : sizes[depth - 1];
        top_start = base_r + addr_t'(top_off) - addr_t'(top_size);
    end

endmodule

// File: test/aligned_stack_allocator_tb.sv
// Top of the aligned stack allocator testbench: clock, reset, configuration and request
// stimulus, result-side back-pressure and the verdict. Depends on asa_pkg, the block and
// aligned_stack_allocator_chk.
`timescale 1ns / 1ps

module aligned_stack_allocator_tb
    import asa_pkg::*;
();

    // The kind field has a fourth code that the block treats as a no-op.
    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_addr = 1'b0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic [71:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tready = 1'b0;
    wire          s_tready;
    wire          m_tvalid;
    wire  [63:0]  m_tdata;

    int           fail_count;
    int           pending;
    int unsigned  live_count;
    addr_t        top_start;
    bytes_t       top_size;
    bytes_t       used;

    int           send_gap_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_req = 0;
    bytes_t       pool_now = POOL_BYTES_RST;

    aligned_stack_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    aligned_stack_allocator_chk chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .live_count (live_count),
        .top_start  (top_start),
        .top_size   (top_size),
        .used       (used)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random stalls, or a long hold-off when the stimulus asks for one.
    initial begin
        int held;
        held = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                held = hold_req;
                hold_req = 0;
            end
            if (held != 0) begin
                m_tready = 1'b0;
                held--;
            end else begin
                m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Moves to the next falling edge, then lets the sender idle for a random while.
    task automatic next_slot();
        @(negedge aclk);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
    endtask

    task automatic put_beat(input logic [KIND_W-1:0] kind, input bytes_t req,
                            input logic [ALIGN_W-1:0] align, input addr_t faddr);
        s_tuser = kind;
        s_tdata = {6'b0, faddr, align, req};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = value;
        if (idx == CFG_POOL_BYTES) pool_now = value[BYTES_W-1:0];
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // One random request, aimed at the current stack so that most frees hit the top block.
    task automatic random_request(input int alloc_pct);
        int unsigned        pick;
        int unsigned        roll;
        int unsigned        rest;
        logic [KIND_W-1:0]  kind;
        bytes_t             req;
        bytes_t             room;
        logic [ALIGN_W-1:0] align;
        addr_t              faddr;
        next_slot();
        pick = $urandom_range(99);
        rest = 100 - alloc_pct;
        req = bytes_t'($urandom);
        align = ALIGN_W'($urandom);
        faddr = $urandom;
        room = (pool_now > used) ? pool_now - used : '0;
        if (pick < alloc_pct) begin
            kind = KIND_ALLOC;
            roll = $urandom_range(9);
            case (roll)
                0: req = room;
                1: req = room + 1'b1;
                2: ;
                3, 4: req = bytes_t'($urandom_range(16));
                default: req = bytes_t'($urandom_range(pool_now / 48 + 8));
            endcase
            roll = $urandom_range(9);
            if (roll < 2) begin
                align = '0;
            end else if (roll < 8) begin
                align = ALIGN_W'(1) << $urandom_range(12);
            end
        end else if (pick < alloc_pct + rest * 17 / 20) begin
            kind = KIND_FREE;
            roll = $urandom_range(19);
            if (live_count != 0) begin
                case (roll)
                    0:  ;
                    1:  faddr = top_start - 1;
                    2:  faddr = top_start + top_size + 1;
                    3:  faddr = top_start;
                    4:  faddr = top_start + top_size;
                    default: faddr = top_start + $urandom_range(top_size);
                endcase
            end
        end else if (pick < alloc_pct + rest * 18 / 20) begin
            kind = KIND_RESET;
        end else begin
            kind = KIND_NOP;
        end
        put_beat(kind, req, align, faddr);
    endtask

    task automatic run_phase(input logic [31:0] base, input logic [31:0] pool,
                             input int gap, input int stall, input int alloc_pct,
                             input int count);
        drain();
        write_reg(CFG_POOL_BASE, base);
        write_reg(CFG_POOL_BYTES, pool);
        send_gap_pct = gap;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            // Halfway through, the receiver holds off long enough to back the block up.
            if (i == count / 2) hold_req = 120;
            random_request(alloc_pct);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: default pool at address zero.
        next_slot(); put_beat(KIND_FREE, '0, '0, $urandom);
        next_slot(); put_beat(KIND_ALLOC, '0, '0, '0);
        next_slot(); put_beat(KIND_ALLOC, 21'd100, 13'd16, '0);
        next_slot(); put_beat(KIND_ALLOC, 21'd1, 13'd4096, '0);
        next_slot(); put_beat(KIND_ALLOC, 21'd5, 13'd6, '0);
        next_slot(); put_beat(KIND_ALLOC, 21'h1FFFFF, 13'h1FFF, 32'hFFFFFFFF);
        next_slot(); put_beat(KIND_FREE, '0, '0, top_start - 1);
        next_slot(); put_beat(KIND_FREE, '0, '0, top_start + top_size + 1);
        next_slot(); put_beat(KIND_FREE, '0, '0, top_start + top_size);
        next_slot(); put_beat(KIND_FREE, '0, '0, top_start);
        next_slot(); put_beat(KIND_NOP, 21'h1FFFFF, 13'h1FFF, 32'hFFFFFFFF);
        next_slot(); put_beat(KIND_ALLOC, 21'd1048576, '0, '0);
        next_slot(); put_beat(KIND_RESET, '0, '0, '0);
        next_slot(); put_beat(KIND_ALLOC, 21'd1048576, '0, '0);
        next_slot(); put_beat(KIND_ALLOC, '0, 13'd1, '0);
        next_slot(); put_beat(KIND_ALLOC, 21'd1, '0, '0);
        next_slot(); put_beat(KIND_FREE, '0, '0, top_start);
        next_slot(); put_beat(KIND_FREE, '0, '0, top_start + 21'd4096);
        next_slot(); put_beat(KIND_FREE, '0, '0, top_start);

        // Directed: a pool that starts one byte short of the address wrap.
        drain();
        write_reg(CFG_POOL_BASE, 32'hFFFFFFFF);
        write_reg(CFG_POOL_BYTES, 32'hFFFFFFFF);
        next_slot(); put_beat(KIND_ALLOC, 21'd3, 13'd4, '0);
        next_slot(); put_beat(KIND_ALLOC, 21'd8, 13'd8, '0);
        next_slot(); put_beat(KIND_FREE, '0, '0, top_start + 1);
        next_slot(); put_beat(KIND_FREE, '0, '0, top_start);
        next_slot(); put_beat(KIND_FREE, '0, '0, '0);

        run_phase(32'h0, 32'd1048576, 0, 0, 55, 206);
        run_phase(32'hFFFFFFFF, 32'h001FFFFF, 46, 0, 60, 206);
        run_phase($urandom, 32'd4096, 0, 46, 90, 206);
        // The stack left by the previous phase now sits above a pool of zero bytes.
        run_phase(32'hFFFFF003, 32'd0, 27, 27, 50, 206);
        run_phase($urandom, 32'd1048576, 0, 0, 90, 206);
        run_phase($urandom, $urandom, 46, 0, 70, 206);
        run_phase(32'h0, 32'd65536, 0, 46, 55, 206);
        run_phase($urandom, 32'd1048576, 27, 27, 65, 206);

        drain();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
